>>> hdl/dsp_pkg.sv
package dsp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int WEIGHT_BITS  = 24;
  localparam int DIST_BITS    = 32;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VIDX_W + 1;
  localparam int EADDR_W      = 2 * VIDX_W;
  localparam int EDGE_DEPTH   = MAX_VERTICES * MAX_VERTICES;
  localparam int EWORD_W      = WEIGHT_BITS + 1;
  localparam int DWORD_W      = DIST_BITS + VIDX_W + 1;

  localparam logic [DIST_BITS-1:0] DIST_ONES = '1;
  localparam logic [DIST_BITS-1:0] DIST_CAP  = DIST_ONES - DIST_BITS'(1);
  localparam logic [CNT_W-1:0]     VCOUNT_RESET = CNT_W'(MAX_VERTICES);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SCAN_END,
    ST_PICK,
    ST_RELAX,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_QREAD,
    ST_QOUT
  } state_t;

  typedef struct packed {
    logic ready;
    logic clr_write;
    logic edge_write;
    logic run_init;
    logic scan;
    logic relax;
    logic pick;
    logic query;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  opcode;
    logic in_valid;
    logic start_ok;
    logic last_issue;
    logic clr_done;
    logic found;
    logic out_free;
  } status_t;

endpackage

>>> hdl/dsp_ram.sv
module dsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/dsp_ctrl.sv
module dsp_ctrl import dsp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (status.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (status.in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (status.opcode)
          OP_CLEAR: state_next = ST_CLEAR;
          OP_ADD: begin
            cmd.edge_write = 1'b1;
            state_next = ST_IDLE;
          end
          OP_RUN: begin
            cmd.run_init = 1'b1;
            state_next = status.start_ok ? ST_SCAN : ST_IDLE;
          end
          OP_QUERY: state_next = ST_QREAD;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.last_issue) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: state_next = ST_PICK;
      ST_PICK: begin
        if (status.found) begin
          cmd.pick = 1'b1;
          state_next = ST_RELAX;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RELAX: begin
        cmd.relax = 1'b1;
        if (status.last_issue) state_next = ST_DRAIN1;
      end
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_SCAN;
      ST_QREAD: begin
        cmd.query = 1'b1;
        state_next = ST_QOUT;
      end
      ST_QOUT: begin
        cmd.query = 1'b1;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/dsp_datapath.sv
module dsp_datapath import dsp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic                   cfg_we,
  input  logic [CNT_W-1:0]       cfg_data,
  input  logic                   in_valid,
  input  logic [1:0]             in_opcode,
  input  logic [VIDX_W-1:0]      in_from,
  input  logic [VIDX_W-1:0]      in_to,
  input  logic [WEIGHT_BITS-1:0] in_weight,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VIDX_W-1:0]      out_vertex,
  output logic [DIST_BITS-1:0]   out_distance,
  output logic [VIDX_W-1:0]      out_pred,
  output logic                   out_has_pred,
  output logic                   out_reachable
);

  logic [CNT_W-1:0]       vcount;
  logic [CNT_W-1:0]       n_used;
  op_t                    item_op;
  logic [VIDX_W-1:0]      item_from, item_to;
  logic [WEIGHT_BITS-1:0] item_w;
  logic [CNT_W-1:0]       cnt;
  logic [EADDR_W-1:0]     clr_addr;
  logic [MAX_VERTICES-1:0] dvalid, visited;
  logic                   scan_q, relax_q, s2_valid, s2_exists, found;
  logic [VIDX_W-1:0]      v_q, s2_v, best_u;
  logic [DIST_BITS-1:0]   best_d, s2_alt, s2_dist, rd_dist, alt;
  logic [DIST_BITS:0]     alt_sum;
  logic                   start_ok, upd, cand;

  logic                   e_we;
  logic [EADDR_W-1:0]     e_waddr;
  logic [EWORD_W-1:0]     e_wdata, e_rdata;
  logic                   d_we;
  logic [VIDX_W-1:0]      d_waddr, d_raddr;
  logic [DWORD_W-1:0]     d_wdata, d_rdata;

  logic                   q_ok;
  logic [DIST_BITS-1:0]   q_dist;
  logic                   q_pv;

  always_comb begin
    if (vcount == '0) n_used = CNT_W'(1);
    else if (vcount > VCOUNT_RESET) n_used = VCOUNT_RESET;
    else n_used = vcount;
  end

  always_ff @(posedge clk) begin
    if (rst) vcount <= VCOUNT_RESET;
    else if (cfg_we) vcount <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && in_valid) begin
      item_op   <= op_t'(in_opcode);
      item_from <= in_from;
      item_to   <= in_to;
      item_w    <= in_weight;
    end
  end

  assign start_ok = {1'b0, item_from} < n_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      clr_addr <= '0;
    end else begin
      cnt      <= (cmd.scan || cmd.relax) ? cnt + CNT_W'(1) : '0;
      clr_addr <= cmd.clr_write ? clr_addr + EADDR_W'(1) : '0;
    end
  end

  // edge store: {exists, length}
  assign e_we    = cmd.clr_write || cmd.edge_write;
  assign e_waddr = cmd.clr_write ? clr_addr : {item_from, item_to};
  assign e_wdata = cmd.clr_write ? '0 : {1'b1, item_w};

  dsp_ram #(.WIDTH(EWORD_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr ({best_u, cnt[VIDX_W-1:0]}),
    .rdata (e_rdata)
  );

  // path store: {has_pred, pred, distance}
  assign upd     = s2_valid && s2_exists && (s2_alt < s2_dist);
  assign d_we    = upd || (cmd.run_init && start_ok);
  assign d_waddr = upd ? s2_v : item_from;
  assign d_wdata = upd ? {1'b1, best_u, s2_alt} : '0;
  assign d_raddr = cmd.query ? item_to : cnt[VIDX_W-1:0];

  dsp_ram #(.WIDTH(DWORD_W), .DEPTH(MAX_VERTICES)) u_path_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  assign rd_dist = dvalid[v_q] ? d_rdata[DIST_BITS-1:0] : DIST_ONES;
  assign cand    = scan_q && !visited[v_q] && (rd_dist != DIST_ONES) &&
                   (!found || rd_dist < best_d);
  assign alt_sum = {1'b0, best_d} + (DIST_BITS+1)'(e_rdata[WEIGHT_BITS-1:0]);
  assign alt     = (alt_sum >= {1'b0, DIST_CAP}) ? DIST_CAP : alt_sum[DIST_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_q   <= 1'b0;
      relax_q  <= 1'b0;
      s2_valid <= 1'b0;
      found    <= 1'b0;
      dvalid   <= '0;
      visited  <= '0;
    end else begin
      scan_q   <= cmd.scan;
      relax_q  <= cmd.relax;
      s2_valid <= relax_q;
      if (cmd.run_init || cmd.pick) found <= 1'b0;
      else if (cand) found <= 1'b1;
      if (cmd.run_init) begin
        visited <= '0;
        dvalid  <= start_ok ? (MAX_VERTICES'(1) << item_from) : '0;
      end else begin
        if (cmd.pick) visited[best_u] <= 1'b1;
        if (upd) dvalid[s2_v] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_q       <= cnt[VIDX_W-1:0];
    s2_v      <= v_q;
    s2_alt    <= alt;
    s2_dist   <= rd_dist;
    s2_exists <= e_rdata[WEIGHT_BITS];
    if (cand) begin
      best_u <= v_q;
      best_d <= rd_dist;
    end
  end

  assign q_ok   = ({1'b0, item_to} < n_used) && dvalid[item_to];
  assign q_dist = q_ok ? d_rdata[DIST_BITS-1:0] : DIST_ONES;
  assign q_pv   = q_ok && d_rdata[DWORD_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_vertex    <= item_to;
      out_distance  <= q_dist;
      out_pred      <= q_pv ? d_rdata[DIST_BITS +: VIDX_W] : '0;
      out_has_pred  <= q_pv;
      out_reachable <= q_dist != DIST_ONES;
    end
  end

  always_comb begin
    status.opcode     = item_op;
    status.in_valid   = in_valid;
    status.start_ok   = start_ok;
    status.last_issue = cnt == (n_used - CNT_W'(1));
    status.clr_done   = &clr_addr;
    status.found      = found;
    status.out_free   = !out_valid || out_ready;
  end

endmodule

>>> hdl/dijkstra_shortest_paths.sv
// Single-source shortest paths over a directed graph of up to 64 vertices.
// Requests: clear edges, add edge, run from a start vertex, query a vertex
// (only a query yields a result). After reset, and after each clear request,
// the edge memory is swept clear while s_tready is low. A query can be held
// by an output stall. A run does a minimum search and a relaxation sweep for
// each reached vertex, with one path-memory read per vertex in use in each.
// A finished result waits in the output register while the next request is
// taken.
module dijkstra_shortest_paths import dsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,      // vertex_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,       // from_vertex[5:0], to_vertex[11:6], edge_weight_in[35:12]
  input  logic [1:0]  s_tuser,       // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,       // queried_vertex[5:0], distance[37:6], predecessor[43:38]
  output logic [1:0]  m_tuser        // has_predecessor[0], reachable[1]
);

  cmd_t    cmd;
  status_t status;
  logic [VIDX_W-1:0]    out_vertex, out_pred;
  logic [DIST_BITS-1:0] out_distance;
  logic                 out_has_pred, out_reachable;

  dsp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  dsp_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (s_tvalid),
    .in_opcode     (s_tuser),
    .in_from       (s_tdata[5:0]),
    .in_to         (s_tdata[11:6]),
    .in_weight     (s_tdata[35:12]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_vertex    (out_vertex),
    .out_distance  (out_distance),
    .out_pred      (out_pred),
    .out_has_pred  (out_has_pred),
    .out_reachable (out_reachable)
  );

  assign s_tready = cmd.ready;
  assign m_tdata  = {4'b0, out_pred, out_distance, out_vertex};
  assign m_tuser  = {out_reachable, out_has_pred};

  a_sweep_after_reset: assert property (@(posedge clk) $past(rst) |-> !s_tready)
    else $error("request taken during edge sweep");

  a_pred_reached: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[1])
    else $error("predecessor on unreached vertex");

  a_pred_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[43:38] == 6'd0)
    else $error("predecessor not zero without flag");

endmodule
